FILE: sv/http_response_framer_assert.svh
// Assertion macros for the HTTP response framer.
// Expects clk and rst_n in scope at the point of use; no other dependencies.
`ifndef HTTP_RESPONSE_FRAMER_ASSERT_SVH
`define HTTP_RESPONSE_FRAMER_ASSERT_SVH

`ifndef SYNTH

`define HRF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer assertion failed: same-cycle implication");

`define HRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer assertion failed: next-cycle implication");

`else

`define HRF_ASSERT_IMPLY(lbl, ante, cons)

`define HRF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: sv/hrf_pkg.sv
// Shared types, codes and constants for the HTTP response framer.
// No dependencies; imported by every framer module.
`timescale 1ns / 1ps
`default_nettype none

package hrf_pkg;

  localparam int LengthBits = 32;
  localparam int KeyLen     = 15;
  localparam int OutLenBits = 32;

  typedef logic [LengthBits-1:0] len_t;
  typedef logic [4:0]            mpos_t;

  localparam mpos_t MatchFailed = 5'd31;

  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5a;
  localparam logic [7:0] CaseGap   = 8'h20;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_CLOSE   = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_HEADER      = 3'd0,
    PH_COUNTED     = 3'd1,
    PH_UNTIL_CLOSE = 3'd2,
    PH_COMPLETE    = 3'd3,
    PH_INCOMPLETE  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    VM_NONE   = 2'd0,
    VM_SKIP   = 2'd1,
    VM_DIGITS = 2'd2,
    VM_DONE   = 2'd3
  } vmode_t;

  typedef enum logic [1:0] {
    LEN_HOLD  = 2'd0,
    LEN_CLEAR = 2'd1,
    LEN_DIGIT = 2'd2
  } len_op_t;

  typedef struct packed {
    logic   prev_cr;
    logic   has_chars;
    mpos_t  match_pos;
    vmode_t vmode;
  } line_t;

  typedef struct packed {
    line_t      line;
    len_op_t    len_op;
    logic [3:0] digit;
    logic       hdr_end;
    logic       set_have;
  } scan_t;

  localparam line_t LineClear = '{
    prev_cr:   1'b0,
    has_chars: 1'b0,
    match_pos: 5'd0,
    vmode:     VM_NONE
  };

  // "content-length:" in lower case
  function automatic logic [7:0] key_char(input mpos_t pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = 8'h63;
      5'd1:    c = 8'h6f;
      5'd2:    c = 8'h6e;
      5'd3:    c = 8'h74;
      5'd4:    c = 8'h65;
      5'd5:    c = 8'h6e;
      5'd6:    c = 8'h74;
      5'd7:    c = 8'h2d;
      5'd8:    c = 8'h6c;
      5'd9:    c = 8'h65;
      5'd10:   c = 8'h6e;
      5'd11:   c = 8'h67;
      5'd12:   c = 8'h74;
      5'd13:   c = 8'h68;
      5'd14:   c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/hrf_hdr_scan.sv
// Header byte scanner: line ends, key match and value-mode tracking.
// Depends on hrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrf_hdr_scan (
  input  wire logic [7:0]     data_byte,
  input  wire hrf_pkg::line_t line_i,
  output hrf_pkg::scan_t      scan_o
);
  import hrf_pkg::*;

  logic [7:0] lc;
  logic       is_ws;
  logic       is_digit;
  vmode_t     mode;

  assign is_ws    = (data_byte == CharSpace) || (data_byte == CharTab);
  assign is_digit = (data_byte >= CharZero) && (data_byte <= CharNine);
  assign lc       = ((data_byte >= CharUpA) && (data_byte <= CharUpZ)) ?
                    8'(data_byte + CaseGap) : data_byte;

  always_comb begin
    scan_o          = '0;
    scan_o.line     = line_i;
    scan_o.len_op   = LEN_HOLD;
    scan_o.digit    = 4'(data_byte - CharZero);
    scan_o.hdr_end  = 1'b0;
    scan_o.set_have = 1'b0;
    mode            = line_i.vmode;
    if (line_i.prev_cr && (data_byte == CharLf)) begin
      scan_o.line    = LineClear;
      scan_o.hdr_end = !line_i.has_chars;
    end else begin
      scan_o.line.has_chars = line_i.has_chars | line_i.prev_cr | (data_byte != CharCr);
      scan_o.line.prev_cr   = (data_byte == CharCr);
      if ((mode == VM_SKIP) && !is_ws) begin
        mode = VM_DIGITS;
      end
      case (mode)
        VM_SKIP: begin
        end
        VM_DIGITS: begin
          if (is_digit) begin
            scan_o.len_op     = LEN_DIGIT;
            scan_o.line.vmode = VM_DIGITS;
          end else begin
            scan_o.line.vmode = VM_DONE;
          end
        end
        VM_DONE: begin
        end
        default: begin
          if (line_i.match_pos < mpos_t'(KeyLen)) begin
            if (lc == key_char(line_i.match_pos)) begin
              scan_o.line.match_pos = mpos_t'(line_i.match_pos + 5'd1);
              if (line_i.match_pos == mpos_t'(KeyLen - 1)) begin
                scan_o.line.vmode = VM_SKIP;
                scan_o.len_op     = LEN_CLEAR;
                scan_o.set_have   = 1'b1;
              end
            end else begin
              scan_o.line.match_pos = MatchFailed;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/hrf_len_acc.sv
// Saturating decimal accumulator for the content length: len * 10 + digit.
// Depends on hrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrf_len_acc (
  input  wire hrf_pkg::len_t len_i,
  input  wire logic [3:0]    digit,
  output hrf_pkg::len_t      len_o
);
  import hrf_pkg::*;

  logic [LengthBits+3:0] wide;
  logic [LengthBits+3:0] ext;

  assign ext  = {4'b0000, len_i};
  assign wide = (ext << 3) + (ext << 1) + {{LengthBits{1'b0}}, digit};

  // saturate on any carry past the length width
  assign len_o = (wide[LengthBits+3:LengthBits] != 4'b0000) ? '1 : wide[LengthBits-1:0];

endmodule

`default_nettype wire

FILE: sv/http_response_framer.sv
// HTTP response framer: takes one response byte or event per beat and reports, for every
// beat, the framing status, whether a content-length header was seen and its value.
// Throughput is one beat per cycle unless stalled; a taken beat waits in the input register
// and its result is written to the result register once the output advances, the whole state
// update being combinational. The input stalls only while both registers hold a beat and out_ready is low.
// Uses hrf_pkg, hrf_hdr_scan, hrf_len_acc and http_response_framer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

module http_response_framer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic             out_length_known,
  output logic [31:0]      out_body_length
);
  import hrf_pkg::*;

  `include "http_response_framer_assert.svh"

  logic       v0_r;
  logic [1:0] op_r;
  logic [7:0] byte_r;
  logic       adv;
  logic       proc;

  phase_t phase_r, phase_nxt;
  line_t  line_r, line_nxt;
  len_t   parsed_r, parsed_nxt;
  logic   have_r, have_nxt;
  len_t   count_r, count_nxt;

  logic                  out_valid_r;
  logic [2:0]            status_r;
  logic                  known_r;
  logic [OutLenBits-1:0] blen_r;

  scan_t scan;
  len_t  acc_len;

  hrf_hdr_scan u_scan (
    .data_byte (byte_r),
    .line_i    (line_r),
    .scan_o    (scan)
  );

  hrf_len_acc u_acc (
    .len_i (parsed_r),
    .digit (scan.digit),
    .len_o (acc_len)
  );

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !v0_r || adv;
  assign proc     = v0_r && adv;

  always_comb begin
    phase_nxt  = phase_r;
    line_nxt   = line_r;
    parsed_nxt = parsed_r;
    have_nxt   = have_r;
    count_nxt  = count_r;
    case (op_r)
      OP_RESTART: begin
        phase_nxt  = PH_HEADER;
        line_nxt   = LineClear;
        parsed_nxt = '0;
        have_nxt   = 1'b0;
        count_nxt  = '0;
      end
      OP_CLOSE: begin
        if ((phase_r == PH_HEADER) || (phase_r == PH_COUNTED)) begin
          phase_nxt = PH_INCOMPLETE;
        end else if (phase_r == PH_UNTIL_CLOSE) begin
          phase_nxt = PH_COMPLETE;
        end
      end
      OP_DATA: begin
        if (phase_r == PH_HEADER) begin
          line_nxt = scan.line;
          have_nxt = have_r | scan.set_have;
          case (scan.len_op)
            LEN_CLEAR: parsed_nxt = '0;
            LEN_DIGIT: parsed_nxt = acc_len;
            default:   parsed_nxt = parsed_r;
          endcase
          if (scan.hdr_end) begin
            if (!have_r) begin
              phase_nxt = PH_UNTIL_CLOSE;
            end else if (parsed_r == '0) begin
              phase_nxt = PH_COMPLETE;
            end else begin
              phase_nxt = PH_COUNTED;
            end
          end
        end else if (phase_r == PH_COUNTED) begin
          count_nxt = len_t'(count_r + 1'b1);
          if (count_nxt >= parsed_r) begin
            phase_nxt = PH_COMPLETE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HEADER;
      line_r      <= LineClear;
      parsed_r    <= '0;
      have_r      <= 1'b0;
      count_r     <= '0;
    end else begin
      if (in_ready) begin
        v0_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= v0_r;
      end
      if (proc) begin
        phase_r  <= phase_nxt;
        line_r   <= line_nxt;
        parsed_r <= parsed_nxt;
        have_r   <= have_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_op;
      byte_r <= in_data_byte;
    end
    if (proc) begin
      status_r <= phase_nxt;
      known_r  <= have_nxt;
      blen_r   <= OutLenBits'(parsed_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_length_known = known_r;
  assign out_body_length  = blen_r;

  `HRF_ASSERT_NEXT(a_final_holds,
                   proc && (phase_r == PH_COMPLETE) && (op_r != OP_RESTART),
                   phase_r == PH_COMPLETE)
  `HRF_ASSERT_IMPLY(a_no_len_zero, !have_r, parsed_r == '0)
  `HRF_ASSERT_IMPLY(a_counted_len, phase_r == PH_COUNTED, have_r && (parsed_r != '0))
  `HRF_ASSERT_IMPLY(a_stall_full, !in_ready, v0_r && out_valid_r)

endmodule

`default_nettype wire
